@@ rtl/core/tts_pkg.sv @@
package tts_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd100000;

  localparam logic [1:0] FUNC_SET   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] KIND_ID      = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_COMPARE = 2'd2;
  localparam logic [1:0] KIND_CLEARED = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] now;
    logic [63:0] delay;
    logic [31:0] cancel_id;
    logic [15:0] callback_tag;
    logic [31:0] user_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] entry_id;
    logic [15:0] fired_callback;
    logic [31:0] fired_user;
    logic [63:0] compare_value;
    logic        ok;
    logic        last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture request
    logic append;    // write new entry at the tail
    logic scan_rd;   // read entry at read pointer
    logic keep;      // copy read entry to write pointer
    logic track_min; // fold read deadline into the minimum
    logic finish;    // commit the new count
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic scan_done;
    logic hit_clear;
    logic hit_expire;
  } sts_t;

endpackage

@@ rtl/core/tts_datapath.sv @@
module tts_datapath #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  tts_pkg::req_t  req_in,
  input  logic [31:0]    min_interval,
  input  tts_pkg::cmd_t  cmd,
  output tts_pkg::sts_t  sts,
  output logic [31:0]    rd_id,
  output logic [15:0]    rd_cb,
  output logic [31:0]    rd_user,
  output logic [31:0]    new_id,
  output logic [63:0]    cmp_value
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] mem_id   [TABLE_DEPTH];
  logic [63:0] mem_dl   [TABLE_DEPTH];
  logic [15:0] mem_cb   [TABLE_DEPTH];
  logic [31:0] mem_user [TABLE_DEPTH];

  tts_pkg::req_t req;
  logic [CW-1:0] used_count;
  logic [CW-1:0] rptr;
  logic [CW-1:0] wptr;
  logic [31:0]   id_counter;
  logic [63:0]   rd_dl;
  logic [63:0]   least;
  logic          have;
  logic [63:0]   limit;
  logic [63:0]   sum;

  // Read entry is registered; the controller pulses scan_rd then consumes it.
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_id   <= mem_id[rptr[IW-1:0]];
      rd_dl   <= mem_dl[rptr[IW-1:0]];
      rd_cb   <= mem_cb[rptr[IW-1:0]];
      rd_user <= mem_user[rptr[IW-1:0]];
    end
    if (cmd.append) begin
      mem_id[used_count[IW-1:0]]   <= id_counter;
      mem_dl[used_count[IW-1:0]]   <= sum;
      mem_cb[used_count[IW-1:0]]   <= req.callback_tag;
      mem_user[used_count[IW-1:0]] <= req.user_tag;
    end else if (cmd.keep) begin
      mem_id[wptr[IW-1:0]]   <= rd_id;
      mem_dl[wptr[IW-1:0]]   <= rd_dl;
      mem_cb[wptr[IW-1:0]]   <= rd_cb;
      mem_user[wptr[IW-1:0]] <= rd_user;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= req_in;
      limit <= req_in.now + {32'd0, min_interval};
      sum   <= req_in.now + req_in.delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      id_counter <= '0;
      rptr       <= '0;
      wptr       <= '0;
      have       <= 1'b0;
      least      <= '0;
    end else begin
      if (cmd.load) begin
        rptr <= '0;
        wptr <= '0;
        have <= 1'b0;
      end
      if (cmd.append) begin
        used_count <= used_count + 1'b1;
        id_counter <= id_counter + 1'b1;
      end
      if (cmd.scan_rd) rptr <= rptr + 1'b1;
      if (cmd.keep) wptr <= wptr + 1'b1;
      if (cmd.track_min && (!have || rd_dl < least)) begin
        least <= rd_dl;
        have  <= 1'b1;
      end
      if (cmd.finish) used_count <= wptr;
    end
  end

  assign sts.full       = (used_count == CW'(TABLE_DEPTH));
  assign sts.scan_done  = (rptr >= used_count);
  assign sts.hit_clear  = (rd_id == req.cancel_id);
  assign sts.hit_expire = (rd_dl < req.now);
  assign new_id         = id_counter;
  assign cmp_value      = (have && least < limit) ? least : limit;

endmodule

@@ rtl/core/tts_ctrl.sv @@
module tts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     func,
  output logic           out_valid,
  input  logic           out_ready,
  output tts_pkg::rsp_t  out_data,
  output tts_pkg::cmd_t  cmd,
  input  tts_pkg::sts_t  sts,
  input  logic [31:0]    rd_id,
  input  logic [15:0]    rd_cb,
  input  logic [31:0]    rd_user,
  input  logic [31:0]    new_id,
  input  logic [63:0]    cmp_value
);

  typedef enum logic [2:0] {
    S_IDLE, S_SET, S_READ, S_EVAL, S_DONE
  } state_t;

  state_t     state;
  logic [1:0] op;
  logic       found;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_SET:  cmd.append = !sts.full;
      S_READ: cmd.scan_rd = !sts.scan_done && (!out_valid || out_ready);
      S_EVAL: begin
        if (op == tts_pkg::FUNC_CLEAR) begin
          cmd.keep = !sts.hit_clear;
        end else if (!sts.hit_expire) begin
          cmd.keep      = 1'b1;
          cmd.track_min = 1'b1;
        end
      end
      S_DONE: cmd.finish = (op != tts_pkg::FUNC_SET);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op        <= tts_pkg::FUNC_SET;
      found     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op    <= func;
            found <= 1'b0;
            unique case (func)
              tts_pkg::FUNC_SET: state <= S_SET;
              tts_pkg::FUNC_CLEAR, tts_pkg::FUNC_TICK: state <= S_READ;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SET: begin
          out_data  <= '{kind: tts_pkg::KIND_ID,
                         entry_id: (sts.full ? 32'd0 : new_id),
                         fired_callback: 16'd0, fired_user: 32'd0,
                         compare_value: 64'd0, ok: !sts.full, last: 1'b1};
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_READ: begin
          if (!out_valid || out_ready) begin
            state <= sts.scan_done ? S_DONE : S_EVAL;
          end
        end
        S_EVAL: begin
          if (op == tts_pkg::FUNC_CLEAR) begin
            if (sts.hit_clear) found <= 1'b1;
          end else if (sts.hit_expire) begin
            out_data  <= '{kind: tts_pkg::KIND_EXPIRED, entry_id: rd_id,
                           fired_callback: rd_cb, fired_user: rd_user,
                           compare_value: 64'd0, ok: 1'b0, last: 1'b0};
            out_valid <= 1'b1;
          end
          state <= S_READ;
        end
        S_DONE: begin
          if (op == tts_pkg::FUNC_CLEAR) begin
            out_data <= '{kind: tts_pkg::KIND_CLEARED, entry_id: 32'd0,
                          fired_callback: 16'd0, fired_user: 32'd0,
                          compare_value: 64'd0, ok: found, last: 1'b1};
          end else begin
            out_data <= '{kind: tts_pkg::KIND_COMPARE, entry_id: 32'd0,
                          fired_callback: 16'd0, fired_user: 32'd0,
                          compare_value: cmp_value, ok: 1'b0, last: 1'b1};
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/timeout_table_scheduler_core.sv @@
// Timeout table scheduler core.
// A request on the input channel (in_valid/in_ready, payload in_data) is one
// of three operations: set a timeout, clear a timeout by id, or a timer tick.
// Results leave on the output channel (out_valid/out_ready, payload out_data);
// the last result of a request carries the last flag.
// A set passes through S_SET and presents its one result, registered, on its
// return to S_IDLE; a new request is taken only after that result has left.
// A clear or a tick walks the table once and compacts it in place. Each
// stored entry is read in S_READ and judged in S_EVAL, since the single
// read port of the entry memory is registered; S_DONE then gives the
// final result.
// A tick emits one result for each expired entry, then the compare value.
// If the receiver stalls, the walk pauses before the next entry while a
// result is waiting, so nothing is lost. One request is in work at a time.
// Reset (rst, synchronous) empties the table and zeroes the id counter;
// min_interval returns to 100000. The cfg_we/cfg_data port writes
// min_interval and should be used only while the block is idle.
module timeout_table_scheduler_core #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tts_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tts_pkg::rsp_t out_data,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data
);

  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;
  logic [31:0]   min_interval;
  logic [31:0]   rd_id;
  logic [15:0]   rd_cb;
  logic [31:0]   rd_user;
  logic [31:0]   new_id;
  logic [63:0]   cmp_value;

  // The one configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= tts_pkg::MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      min_interval <= cfg_data;
    end
  end

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts),
    .rd_id     (rd_id),
    .rd_cb     (rd_cb),
    .rd_user   (rd_user),
    .new_id    (new_id),
    .cmp_value (cmp_value)
  );

  tts_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_in       (in_data),
    .min_interval (min_interval),
    .cmd          (cmd),
    .sts          (sts),
    .rd_id        (rd_id),
    .rd_cb        (rd_cb),
    .rd_user      (rd_user),
    .new_id       (new_id),
    .cmp_value    (cmp_value)
  );

endmodule

@@ test/timeout_table_scheduler_core_tb.sv @@
`timescale 1ns / 100ps

// Testbench for the timeout table scheduler core.
// Requests (set, clear, tick, and the unused operation code) are sent over the
// input channel. A behavioral model of the timeout table, kept in this file,
// works out the results each accepted request should produce and queues them.
// A separate process compares each result leaving the block, field by field,
// with the oldest queued result.
module timeout_table_scheduler_core_tb;

  localparam int DEPTH = tts_pkg::TABLE_DEPTH_DEFAULT;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tts_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tts_pkg::rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  timeout_table_scheduler_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Model of the timeout table.
  logic [31:0] tbl_id [DEPTH];
  logic [63:0] tbl_deadline [DEPTH];
  logic [15:0] tbl_callback [DEPTH];
  logic [31:0] tbl_user [DEPTH];
  int unsigned tbl_count;
  logic [31:0] next_id;
  logic [31:0] min_gap;

  tts_pkg::rsp_t pending_results[$];
  int unsigned error_count = 0;

  // Idle percentages for the sender and the receiver; hold_cycles forces a
  // long receiver stall when set.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic drop_entry(input int unsigned pos);
    for (int unsigned j = pos; j + 1 < tbl_count; j++) begin
      tbl_id[j] = tbl_id[j+1];
      tbl_deadline[j] = tbl_deadline[j+1];
      tbl_callback[j] = tbl_callback[j+1];
      tbl_user[j] = tbl_user[j+1];
    end
    tbl_count--;
  endtask

  // Apply one request to the model and queue the results it produces.
  task automatic predict_results(input tts_pkg::req_t rq);
    tts_pkg::rsp_t r;
    int unsigned i;
    int unsigned first;
    logic found;
    logic have;
    logic [63:0] least;
    logic [63:0] limit;
    first = pending_results.size();
    r = '0;
    case (rq.func)
      tts_pkg::FUNC_SET: begin
        r.kind = tts_pkg::KIND_ID;
        if (tbl_count < DEPTH) begin
          tbl_id[tbl_count] = next_id;
          tbl_deadline[tbl_count] = rq.now + rq.delay;
          tbl_callback[tbl_count] = rq.callback_tag;
          tbl_user[tbl_count] = rq.user_tag;
          tbl_count++;
          r.entry_id = next_id;
          r.ok = 1'b1;
          next_id++;
        end
        pending_results.push_back(r);
      end
      tts_pkg::FUNC_CLEAR: begin
        found = 1'b0;
        i = 0;
        while (i < tbl_count) begin
          if (tbl_id[i] == rq.cancel_id) begin
            drop_entry(i);
            found = 1'b1;
          end else begin
            i++;
          end
        end
        r.kind = tts_pkg::KIND_CLEARED;
        r.ok = found;
        pending_results.push_back(r);
      end
      tts_pkg::FUNC_TICK: begin
        limit = rq.now + {32'd0, min_gap};
        have = 1'b0;
        least = '0;
        i = 0;
        while (i < tbl_count) begin
          if (tbl_deadline[i] < rq.now) begin
            r = '0;
            r.kind = tts_pkg::KIND_EXPIRED;
            r.entry_id = tbl_id[i];
            r.fired_callback = tbl_callback[i];
            r.fired_user = tbl_user[i];
            pending_results.push_back(r);
            drop_entry(i);
          end else begin
            if (!have || tbl_deadline[i] < least) begin
              least = tbl_deadline[i];
              have = 1'b1;
            end
            i++;
          end
        end
        r = '0;
        r.kind = tts_pkg::KIND_COMPARE;
        r.compare_value = (have && least < limit) ? least : limit;
        pending_results.push_back(r);
      end
      default: ;
    endcase
    if (pending_results.size() > first) begin
      pending_results[pending_results.size()-1].last = 1'b1;
    end
  endtask

  // Send one request, honoring the sender idle rate, and predict on acceptance.
  // Valid stays high after acceptance until the next idle cycle or drain.
  task automatic send_request(input tts_pkg::req_t rq);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(rq);
  endtask

  // Receiver: check each accepted result against the oldest queued one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        tts_pkg::rsp_t e;
        e = pending_results.pop_front();
        if (out_data.kind !== e.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, e.kind));
        if (out_data.entry_id !== e.entry_id)
          report_mismatch($sformatf("entry_id %0h, expected %0h",
                                    out_data.entry_id, e.entry_id));
        if (out_data.fired_callback !== e.fired_callback)
          report_mismatch($sformatf("fired_callback %0h, expected %0h",
                                    out_data.fired_callback, e.fired_callback));
        if (out_data.fired_user !== e.fired_user)
          report_mismatch($sformatf("fired_user %0h, expected %0h",
                                    out_data.fired_user, e.fired_user));
        if (out_data.compare_value !== e.compare_value)
          report_mismatch($sformatf("compare_value %0h, expected %0h",
                                    out_data.compare_value, e.compare_value));
        if (out_data.ok !== e.ok)
          report_mismatch($sformatf("ok %0b, expected %0b", out_data.ok, e.ok));
        if (out_data.last !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_data.last, e.last));
      end
    end
  end

  // Ready is drawn at random, or held low while the long stall is counted here,
  // so the sender keeps offering requests while the output stays blocked and the block backs up.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Wait until all expected results have arrived, then let a full table
  // walk pass so that an unused request cannot still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_min_gap(input logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_gap = value;
  endtask

  function automatic tts_pkg::req_t make_req(input logic [1:0] f, input logic [63:0] now_v,
                                             input logic [63:0] dly, input logic [31:0] cid,
                                             input logic [15:0] cb, input logic [31:0] usr);
    tts_pkg::req_t rq;
    rq.func = f;
    rq.now = now_v;
    rq.delay = dly;
    rq.cancel_id = cid;
    rq.callback_tag = cb;
    rq.user_tag = usr;
    return rq;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Directed: field extremes, every operation and the named corner cases.
  task automatic test_directed();
    // Tick on an empty table, with the default interval.
    send_request(make_req(tts_pkg::FUNC_TICK, 64'd1000, '0, '0, '0, '0));
    // Extremes of set fields; the first deadline wraps past 2^64.
    send_request(make_req(tts_pkg::FUNC_SET, '1, 64'd5, '1, 16'hffff, '1));
    send_request(make_req(tts_pkg::FUNC_SET, '0, '0, '0, '0, '0));
    send_request(make_req(tts_pkg::FUNC_SET, 64'd100, '1, '0, 16'h1234, 32'hdeadbeef));
    // Unused operation code: nothing comes back.
    send_request(make_req(FUNC_NONE, rand64(), rand64(), '1, '1, '1));
    // Clear a present id, then the same id again (not found).
    send_request(make_req(tts_pkg::FUNC_CLEAR, '0, '0, 32'd1, '0, '0));
    send_request(make_req(tts_pkg::FUNC_CLEAR, '0, '0, 32'd1, '0, '0));
    send_request(make_req(tts_pkg::FUNC_CLEAR, '0, '0, '1, '0, '0));
    // Ticks that expire the wrapped entries; in the second, now + interval wraps too.
    send_request(make_req(tts_pkg::FUNC_TICK, 64'd10, '0, '0, '0, '0));
    send_request(make_req(tts_pkg::FUNC_TICK, '1, '0, '0, '0, '0));
    // Fill the table past full, then expire everything at once.
    for (int k = 0; k < DEPTH + 2; k++)
      send_request(make_req(tts_pkg::FUNC_SET, 64'd50, 64'(k), '0, 16'(k), 32'(k)));
    send_request(make_req(tts_pkg::FUNC_TICK, 64'd1000, '0, '0, '0, '0));
  endtask

  // Random requests, mostly well formed: ids near the live ones, small times.
  task automatic test_random(input int unsigned count);
    tts_pkg::req_t rq;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99, 0);
      rq = make_req(tts_pkg::FUNC_SET, {48'd0, 16'($urandom)}, {52'd0, 12'($urandom)},
                    $urandom, $urandom, $urandom);
      if ($urandom_range(9, 0) == 0) begin
        rq.now = rand64();
        rq.delay = rand64();
      end
      if (pick < 50) begin
        rq.func = tts_pkg::FUNC_SET;
      end else if (pick < 70) begin
        rq.func = tts_pkg::FUNC_CLEAR;
        if ($urandom_range(3, 0) != 0)
          rq.cancel_id = next_id - 32'($urandom_range(DEPTH + 2, 1));
      end else if (pick < 97) begin
        rq.func = tts_pkg::FUNC_TICK;
      end else begin
        rq.func = FUNC_NONE;
      end
      send_request(rq);
    end
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int k = 0; k < DEPTH; k++)
      send_request(make_req(tts_pkg::FUNC_SET, 64'd10, 64'd1, '0, 16'(k), 32'(k)));
    send_request(make_req(tts_pkg::FUNC_TICK, 64'd1000, '0, '0, '0, '0));
    for (int k = 0; k < 6; k++)
      send_request(make_req(tts_pkg::FUNC_TICK, 64'(k), '0, '0, '0, '0));
  endtask

  task automatic test_intervals();
    write_min_gap(32'd1);
    test_random(60);
    write_min_gap('1);
    test_random(60);
    write_min_gap(32'd300);
    test_random(60);
  endtask

  initial begin
    tbl_count = 0;
    next_id = '0;
    min_gap = tts_pkg::MIN_INTERVAL_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 70;
    test_directed();
    test_random(50);
    test_backpressure();

    send_idle_pct = 70;
    recv_idle_pct = 24;
    test_intervals();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_min_gap(32'd5000);
    test_random(40);
    test_backpressure();

    drain();
    if (error_count == 0) begin
      $display("** timeout_table_scheduler_core: PASSED **");
    end else begin
      $display("** timeout_table_scheduler_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** timeout_table_scheduler_core: FAILED **");
    $finish;
  end

endmodule
